>>> design/qrm_pkg.sv
// ----------------------------------------------------------------------------
// qrm_pkg
// shared widths, types and constants of the quaternion to rotation matrix block
// ----------------------------------------------------------------------------
package qrm_pkg;

  localparam int DW    = 16;          // component and element width
  localparam int PW    = 2 * DW;      // product width
  localparam int SW    = 2 * DW + 1;  // squared length and magnitude width
  localparam int NW    = 2 * DW + 2;  // signed numerator width
  localparam int RW    = SW + 1;      // shifted partial remainder width
  localparam int NLANE = 9;           // matrix elements

  // one in Q2.14 at the default width
  localparam logic [DW-1:0] ONE = DW'(1) << (DW - 2);
  localparam logic signed [DW-1:0] ONE_S = ONE;

  // diagonal lanes r0c0, r1c1, r2c2
  localparam logic [NLANE-1:0] DIAG_MASK = 9'b100010001;

  typedef logic [SW-1:0]               mag_t;
  typedef mag_t [NLANE-1:0]            mag_vec_t;
  typedef logic [DW-1:0]               quo_t;
  typedef quo_t [NLANE-1:0]            quo_vec_t;

  // control that rides along the divider stages
  typedef struct packed {
    logic             valid;
    logic             degen;
    logic [NLANE-1:0] neg;
  } side_t;

endpackage

>>> design/qrm_if.sv
// ----------------------------------------------------------------------------
// qrm_if
// valid/ready channels for quaternions in and matrices out
// ----------------------------------------------------------------------------
interface qrm_in_if;
  logic                         valid;
  logic                         ready;
  logic signed [qrm_pkg::DW-1:0] quat_x;
  logic signed [qrm_pkg::DW-1:0] quat_y;
  logic signed [qrm_pkg::DW-1:0] quat_z;
  logic signed [qrm_pkg::DW-1:0] quat_w;

  modport source (output valid, quat_x, quat_y, quat_z, quat_w, input ready);
  modport sink   (input valid, quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface qrm_out_if;
  logic                         valid;
  logic                         ready;
  logic signed [qrm_pkg::DW-1:0] elem_r0c0;
  logic signed [qrm_pkg::DW-1:0] elem_r0c1;
  logic signed [qrm_pkg::DW-1:0] elem_r0c2;
  logic signed [qrm_pkg::DW-1:0] elem_r1c0;
  logic signed [qrm_pkg::DW-1:0] elem_r1c1;
  logic signed [qrm_pkg::DW-1:0] elem_r1c2;
  logic signed [qrm_pkg::DW-1:0] elem_r2c0;
  logic signed [qrm_pkg::DW-1:0] elem_r2c1;
  logic signed [qrm_pkg::DW-1:0] elem_r2c2;
  logic                         degenerate;

  modport source (output valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                  elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, degenerate, input ready);
  modport sink   (input valid, elem_r0c0, elem_r0c1, elem_r0c2, elem_r1c0, elem_r1c1,
                  elem_r1c2, elem_r2c0, elem_r2c1, elem_r2c2, degenerate, output ready);
endinterface

>>> design/qrm_div.sv
// ----------------------------------------------------------------------------
// qrm_div
// nine-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module qrm_div (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  qrm_pkg::mag_vec_t mag_i,
  input  qrm_pkg::mag_t     s_i,
  input  qrm_pkg::side_t    side_i,
  output qrm_pkg::quo_vec_t quo_o,
  output qrm_pkg::side_t    side_o
);

  qrm_pkg::mag_vec_t rem_r  [1:qrm_pkg::DW];
  qrm_pkg::mag_t     s_r    [1:qrm_pkg::DW];
  qrm_pkg::quo_vec_t quo_r  [1:qrm_pkg::DW];
  qrm_pkg::side_t    side_r [1:qrm_pkg::DW];

  qrm_pkg::mag_vec_t rem_in  [0:qrm_pkg::DW-1];
  qrm_pkg::mag_t     s_in    [0:qrm_pkg::DW-1];
  qrm_pkg::quo_vec_t quo_in  [0:qrm_pkg::DW-1];
  qrm_pkg::side_t    side_in [0:qrm_pkg::DW-1];

  genvar k;
  generate
    for (k = 0; k < qrm_pkg::DW; k++) begin : g_stage
      logic [qrm_pkg::NLANE-1:0][qrm_pkg::RW-1:0] sh;
      logic [qrm_pkg::NLANE-1:0]                  ge;
      qrm_pkg::mag_vec_t                          rem_nxt;
      qrm_pkg::quo_vec_t                          quo_nxt;

      if (k == 0) begin : g_first
        assign rem_in[k]  = mag_i;
        assign s_in[k]    = s_i;
        assign quo_in[k]  = '0;
        assign side_in[k] = side_i;
      end else begin : g_next
        assign rem_in[k]  = rem_r[k];
        assign s_in[k]    = s_r[k];
        assign quo_in[k]  = quo_r[k];
        assign side_in[k] = side_r[k];
      end

      always_comb begin
        for (int l = 0; l < qrm_pkg::NLANE; l++) begin
          // first stage takes the integer bit, the rest shift in a zero
          if (k == 0) sh[l] = {1'b0, rem_in[k][l]};
          else        sh[l] = {rem_in[k][l], 1'b0};
          ge[l]      = sh[l] >= {1'b0, s_in[k]};
          rem_nxt[l] = ge[l] ? qrm_pkg::SW'(sh[l] - {1'b0, s_in[k]})
                             : qrm_pkg::SW'(sh[l]);
          quo_nxt[l] = {quo_in[k][l][qrm_pkg::DW-2:0], ge[l]};
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          side_r[k+1].valid <= 1'b0;
        end else if (en) begin
          side_r[k+1] <= side_in[k];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k+1] <= rem_nxt;
          s_r[k+1]   <= s_in[k];
          quo_r[k+1] <= quo_nxt;
        end
      end
    end
  endgenerate

  assign quo_o  = quo_r[qrm_pkg::DW];
  assign side_o = side_r[qrm_pkg::DW];

endmodule

>>> design/quaternion_to_rotation_matrix.sv
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix
// normalized quaternion to 3x3 row-vector rotation matrix, fully pipelined
// ----------------------------------------------------------------------------
// Takes one quaternion (x, y, z, w, signed Q4.12) per cycle and returns the nine
// elements of its rotation matrix in signed Q2.14, rounded to nearest with ties
// away from zero. Normalization is folded into the division: each element is
// its raw product sum divided by s = xx+yy+zz+ww. In order, the pipeline has a
// register after the ten multipliers, after the numerator sums and after the
// sign/magnitude split, then DW divider stages (one quotient bit each, nine
// lanes in parallel), and the rounding/output register. Throughput is one
// transaction per cycle; when the output is held off the whole pipeline stalls
// and in_ch.ready drops. An all-zero quaternion gives the identity matrix with
// degenerate set.
module quaternion_to_rotation_matrix (
  input  logic       clk,
  input  logic       rst_n,
  qrm_in_if.sink     in_ch,
  qrm_out_if.source  out_ch
);

  localparam int DW = qrm_pkg::DW;
  localparam int PW = qrm_pkg::PW;
  localparam int NW = qrm_pkg::NW;
  localparam int SW = qrm_pkg::SW;
  localparam int NL = qrm_pkg::NLANE;

  // global advance: moves whenever the output slot is free or being taken
  logic en;
  assign en          = out_ch.ready || !out_ch.valid;
  assign in_ch.ready = en;

  // --- stage 1: products ---
  logic                 v1_r;
  logic signed [PW-1:0] xx_r, yy_r, zz_r, ww_r, xy_r, xz_r, yz_r, wx_r, wy_r, wz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_ch.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xx_r <= PW'(in_ch.quat_x * in_ch.quat_x);
      yy_r <= PW'(in_ch.quat_y * in_ch.quat_y);
      zz_r <= PW'(in_ch.quat_z * in_ch.quat_z);
      ww_r <= PW'(in_ch.quat_w * in_ch.quat_w);
      xy_r <= PW'(in_ch.quat_x * in_ch.quat_y);
      xz_r <= PW'(in_ch.quat_x * in_ch.quat_z);
      yz_r <= PW'(in_ch.quat_y * in_ch.quat_z);
      wx_r <= PW'(in_ch.quat_w * in_ch.quat_x);
      wy_r <= PW'(in_ch.quat_w * in_ch.quat_y);
      wz_r <= PW'(in_ch.quat_w * in_ch.quat_z);
    end
  end

  // --- stage 2: squared length and numerators ---
  // diagonal s - 2(yy+zz) is written as xx+ww-yy-zz, so no chain through s
  logic signed [NW-1:0] exx, eyy, ezz, eww;
  logic signed [NW-1:0] num_nxt [NL];
  logic signed [NW-1:0] num_r   [NL];
  logic signed [NW-1:0] s_sum;
  logic [SW-1:0]        s2_r;
  logic                 v2_r;

  always_comb begin
    exx   = NW'(xx_r);
    eyy   = NW'(yy_r);
    ezz   = NW'(zz_r);
    eww   = NW'(ww_r);
    s_sum = exx + eyy + ezz + eww;
    num_nxt[0] = exx + eww - eyy - ezz;
    num_nxt[1] = (NW'(xy_r) + NW'(wz_r)) <<< 1;
    num_nxt[2] = (NW'(xz_r) - NW'(wy_r)) <<< 1;
    num_nxt[3] = (NW'(xy_r) - NW'(wz_r)) <<< 1;
    num_nxt[4] = eyy + eww - exx - ezz;
    num_nxt[5] = (NW'(yz_r) + NW'(wx_r)) <<< 1;
    num_nxt[6] = (NW'(xz_r) + NW'(wy_r)) <<< 1;
    num_nxt[7] = (NW'(yz_r) - NW'(wx_r)) <<< 1;
    num_nxt[8] = ezz + eww - exx - eyy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_r <= num_nxt;
      s2_r  <= SW'(s_sum);
    end
  end

  // --- stage 3: sign and magnitude, zero-length detect ---
  qrm_pkg::mag_vec_t mag_nxt, mag_r;
  qrm_pkg::side_t    side_nxt, side3_r;
  qrm_pkg::mag_t     s3_r;

  always_comb begin
    side_nxt.valid = v2_r;
    side_nxt.degen = (s2_r == '0);
    for (int l = 0; l < NL; l++) begin
      side_nxt.neg[l] = num_r[l][NW-1];
      mag_nxt[l]      = num_r[l][NW-1] ? SW'(-num_r[l]) : SW'(num_r[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) side3_r.valid <= 1'b0;
    else if (en) side3_r <= side_nxt;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r <= mag_nxt;
      s3_r  <= s2_r;
    end
  end

  // --- divider: t = floor(mag * 2^(DW-1) / s) per lane ---
  qrm_pkg::quo_vec_t quo;
  qrm_pkg::side_t    side_d;

  qrm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .mag_i  (mag_r),
    .s_i    (s3_r),
    .side_i (side3_r),
    .quo_o  (quo),
    .side_o (side_d)
  );

  // --- output: round half up on magnitude, clamp, restore sign, identity if degenerate ---
  logic [DW:0]          tp1  [NL];
  logic [DW-1:0]        q    [NL];
  logic signed [DW-1:0] elem_nxt [NL];
  logic signed [DW-1:0] elem_r   [NL];
  logic                 degen_r;
  logic                 vo_r;

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      tp1[l] = {1'b0, quo[l]} + (DW+1)'(1);
      q[l]   = tp1[l][DW:1];
      if (q[l] > qrm_pkg::ONE) q[l] = qrm_pkg::ONE;
      if (side_d.degen)          elem_nxt[l] = qrm_pkg::DIAG_MASK[l] ? qrm_pkg::ONE_S : '0;
      else if (side_d.neg[l])    elem_nxt[l] = -$signed(q[l]);
      else                       elem_nxt[l] = $signed(q[l]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= side_d.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      elem_r  <= elem_nxt;
      degen_r <= side_d.degen;
    end
  end

  assign out_ch.valid      = vo_r;
  assign out_ch.elem_r0c0  = elem_r[0];
  assign out_ch.elem_r0c1  = elem_r[1];
  assign out_ch.elem_r0c2  = elem_r[2];
  assign out_ch.elem_r1c0  = elem_r[3];
  assign out_ch.elem_r1c1  = elem_r[4];
  assign out_ch.elem_r1c2  = elem_r[5];
  assign out_ch.elem_r2c0  = elem_r[6];
  assign out_ch.elem_r2c1  = elem_r[7];
  assign out_ch.elem_r2c2  = elem_r[8];
  assign out_ch.degenerate = degen_r;

  // --- assertions ---
  // degenerate transaction carries ones on the diagonal and zeros in r0c1, r1c2 and r2c0
  a_degen_identity: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.degenerate |->
      out_ch.elem_r0c0 == qrm_pkg::ONE_S && out_ch.elem_r1c1 == qrm_pkg::ONE_S &&
      out_ch.elem_r2c2 == qrm_pkg::ONE_S && out_ch.elem_r0c1 == '0 &&
      out_ch.elem_r1c2 == '0 && out_ch.elem_r2c0 == '0)
    else $error("degenerate output is not identity");

  // rounding and clamp keep every element within unit magnitude; checked on r0c0 and r1c2
  a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |->
      out_ch.elem_r0c0 <= qrm_pkg::ONE_S && out_ch.elem_r0c0 >= -qrm_pkg::ONE_S &&
      out_ch.elem_r1c2 <= qrm_pkg::ONE_S && out_ch.elem_r1c2 >= -qrm_pkg::ONE_S)
    else $error("matrix element outside unit range");

  // a held result must not advance the pipeline under it
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=> $stable(elem_r[4]) && $stable(degen_r))
    else $error("stalled result changed");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_ch.valid)
    else $error("output valid directly after reset");

endmodule

>>> bench/quaternion_to_rotation_matrix_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// quaternion_to_rotation_matrix_tb
// checks every matrix against an exact rational predictor or a table entry under random flow
// ----------------------------------------------------------------------------
// A table of directed quaternions comes first: zero length, single axes,
// extremes and sign mixes. Random quaternions follow, mostly full-scale values
// and some small ones, across phases of sender gaps and receiver stalls. Each
// output transaction is compared field by field with the oldest expected matrix.
module quaternion_to_rotation_matrix_tb;

  localparam int DW = qrm_pkg::DW;

  typedef struct {
    logic signed [DW-1:0] x, y, z, w;
  } quat_t;

  typedef struct {
    logic signed [DW-1:0] e [9];
    logic                 degen;
  } matrix_t;

  typedef struct {
    quat_t   q;
    bit      typed;   // expected matrix given in the table
    matrix_t m;
  } vec_row_t;

  localparam int N_RANDOM   = 1500;
  localparam int STALL_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 3 * (DW + 4);

  logic clk;
  logic rst_n;

  qrm_in_if  in_ch ();
  qrm_out_if out_ch ();

  quaternion_to_rotation_matrix DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  matrix_t    expected_matrices [$];
  int         error_count = 0;
  int         idle_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // round(num * 2^(DW-2) / s), ties away from zero, clamped to one
  function automatic logic signed [DW-1:0] scaled_ratio(logic signed [127:0] num,
                                                        logic signed [127:0] s);
    logic signed [127:0] mag;
    logic signed [127:0] q;
    mag = (num < 0) ? -num : num;
    q   = ((mag <<< (DW - 1)) + s) / (s <<< 1);
    if (q > (128'sd1 <<< (DW - 2))) q = 128'sd1 <<< (DW - 2);
    return (num < 0) ? DW'(-q) : DW'(q);
  endfunction

  function automatic matrix_t rotation_of(quat_t q);
    matrix_t m;
    logic signed [127:0] x, y, z, w, xx, yy, zz, ww, xy, xz, yz, wx, wy, wz, s;
    x = q.x; y = q.y; z = q.z; w = q.w;
    xx = x * x; yy = y * y; zz = z * z; ww = w * w;
    s  = xx + yy + zz + ww;
    if (s == 0) begin
      foreach (m.e[k]) m.e[k] = (k % 4 == 0) ? qrm_pkg::ONE_S : '0;
      m.degen = 1'b1;
      return m;
    end
    xy = x * y; xz = x * z; yz = y * z; wx = w * x; wy = w * y; wz = w * z;
    m.e[0] = scaled_ratio(s - 2 * (yy + zz), s);
    m.e[1] = scaled_ratio(2 * (xy + wz), s);
    m.e[2] = scaled_ratio(2 * (xz - wy), s);
    m.e[3] = scaled_ratio(2 * (xy - wz), s);
    m.e[4] = scaled_ratio(s - 2 * (xx + zz), s);
    m.e[5] = scaled_ratio(2 * (yz + wx), s);
    m.e[6] = scaled_ratio(2 * (xz + wy), s);
    m.e[7] = scaled_ratio(2 * (yz - wx), s);
    m.e[8] = scaled_ratio(s - 2 * (xx + yy), s);
    m.degen = 1'b0;
    return m;
  endfunction

  function automatic matrix_t diag_matrix(logic signed [DW-1:0] d0, logic signed [DW-1:0] d1,
                                          logic signed [DW-1:0] d2, logic dg);
    matrix_t m;
    foreach (m.e[k]) m.e[k] = '0;
    m.e[0] = d0; m.e[4] = d1; m.e[8] = d2; m.degen = dg;
    return m;
  endfunction

  function automatic quat_t mk(int x, int y, int z, int w);
    quat_t q;
    q.x = DW'(x); q.y = DW'(y); q.z = DW'(z); q.w = DW'(w);
    return q;
  endfunction

  function automatic logic signed [DW-1:0] rand_comp();
    case ($urandom_range(0, 9))
      0:       return DW'($urandom_range(0, 7)) - DW'(3);
      1:       return {1'b1, {(DW-1){1'b0}}};
      2:       return {1'b0, {(DW-1){1'b1}}};
      3:       return '0;
      default: return DW'($urandom());
    endcase
  endfunction

  // drive one quaternion and hold it until the block takes it
  task automatic send_quat(quat_t q, bit typed, matrix_t m);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.quat_x <= q.x;
    in_ch.quat_y <= q.y;
    in_ch.quat_z <= q.z;
    in_ch.quat_w <= q.w;
    expected_matrices.insert(expected_matrices.size(), typed ? m : rotation_of(q));
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // receiver: random stalls, check on every accepted transaction
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_matrices.size() == 0) begin
          $display("%0t: unexpected matrix r0c0=%0d", $time, out_ch.elem_r0c0);
          error_count++;
        end else begin
          matrix_t exp_m;
          logic signed [DW-1:0] act [9];
          exp_m = expected_matrices.pop_front();
          act = '{out_ch.elem_r0c0, out_ch.elem_r0c1, out_ch.elem_r0c2,
                  out_ch.elem_r1c0, out_ch.elem_r1c1, out_ch.elem_r1c2,
                  out_ch.elem_r2c0, out_ch.elem_r2c1, out_ch.elem_r2c2};
          foreach (act[k])
            if (act[k] !== exp_m.e[k]) begin
              $display("%0t: element %0d expected %0d actual %0d", $time, k,
                       exp_m.e[k], act[k]);
              error_count++;
            end
          if (out_ch.degenerate !== exp_m.degen) begin
            $display("%0t: degenerate expected %0b actual %0b", $time, exp_m.degen,
                     out_ch.degenerate);
            error_count++;
          end
        end
      end
      out_ch.ready <= !(recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    vec_row_t dir_table [$];
    matrix_t  none;
    int       phase;
    quat_t    q;
    logic signed [DW-1:0] one_v, neg_v;
    one_v = qrm_pkg::ONE_S;
    neg_v = -qrm_pkg::ONE_S;
    none = diag_matrix('0, '0, '0, 1'b0);
    dir_table = '{
      '{mk(0, 0, 0, 0), 1, diag_matrix(one_v, one_v, one_v, 1'b1)},
      '{mk(0, 0, 0, 4096), 1, diag_matrix(one_v, one_v, one_v, 1'b0)},
      '{mk(0, 0, 0, -32768), 1, diag_matrix(one_v, one_v, one_v, 1'b0)},
      '{mk(32767, 0, 0, 0), 1, diag_matrix(one_v, neg_v, neg_v, 1'b0)},
      '{mk(0, -32768, 0, 0), 1, diag_matrix(neg_v, one_v, neg_v, 1'b0)},
      '{mk(0, 0, 1, 0), 1, diag_matrix(neg_v, neg_v, one_v, 1'b0)},
      '{mk(-32768, -32768, -32768, -32768), 0, none},
      '{mk(32767, 32767, 32767, 32767), 0, none},
      '{mk(32767, -32768, 32767, -32768), 0, none},
      '{mk(1, 1, 1, 1), 0, none},
      '{mk(-1, 0, 0, 1), 0, none},
      '{mk(1, -1, 0, 0), 0, none},
      '{mk(0, 1, -1, 0), 0, none},
      '{mk(3, 0, 0, 1), 0, none},
      '{mk(1, 2, 3, 4), 0, none},
      '{mk(-4096, 4096, -4096, 4096), 0, none},
      '{mk(21845, -10923, 5461, -1), 0, none},
      '{mk(-1, -1, -1, -1), 0, none}
    };

    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.quat_x = '0;
    in_ch.quat_y = '0;
    in_ch.quat_z = '0;
    in_ch.quat_w = '0;
    out_ch.ready = 1'b1;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) send_quat(dir_table[i].q, dir_table[i].typed, dir_table[i].m);

    // phases: free flow, sender gaps, receiver stalls, both
    for (phase = 0; phase < 4; phase++) begin
      send_idle_pct  = (phase == 1) ? 67 : (phase == 3) ? 19 : 0;
      recv_stall_pct = (phase == 2) ? 67 : (phase == 3) ? 19 : 0;
      repeat (N_RANDOM / 4) begin
        q.x = rand_comp(); q.y = rand_comp(); q.z = rand_comp(); q.w = rand_comp();
        send_quat(q, 0, none);
      end
    end
    in_ch.valid <= 1'b0;

    while (expected_matrices.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

>>> files.f
design/qrm_pkg.sv
design/qrm_if.sv
design/qrm_div.sv
design/quaternion_to_rotation_matrix.sv
bench/quaternion_to_rotation_matrix_tb.sv
